>>> hw/rtl/vss_pkg.sv
// vss_pkg: shared types, register indexes and constants of the VGA scanline sequencer.
// Used by vss_line_step and vga_scanline_sequencer; depends on nothing.

package vss_pkg;

   localparam int LineW   = 10;
   localparam int SubW    = 3;
   localparam int RepW    = 4;
   localparam int SrcW    = 8;
   localparam int StrideW = 9;
   localparam int OffsetW = 17;
   localparam int CmdW    = 8;
   localparam int CsrIdxW = 3;

   localparam logic [CmdW-1:0] FRAME_END_CMD = 8'd192;
   localparam logic [SrcW-1:0] SRC_LINE_MAX  = 8'd255;
   localparam logic [RepW-1:0] REPEAT_MIN    = 4'd1;
   localparam logic [RepW-1:0] REPEAT_MAX    = 4'd8;

   // reset values of the configuration registers
   localparam logic [LineW-1:0]   ACTIVE_START_RST = 10'd48;
   localparam logic [LineW-1:0]   ACTIVE_END_RST   = 10'd432;
   localparam logic [LineW-1:0]   VSYNC_START_RST  = 10'd490;
   localparam logic [LineW-1:0]   VSYNC_END_RST    = 10'd492;
   localparam logic [LineW-1:0]   FRAME_FIRST_RST  = 10'd0;
   localparam logic [LineW-1:0]   FRAME_LAST_RST   = 10'd524;
   localparam logic [RepW-1:0]    REPEAT_RST       = 4'd2;
   localparam logic [StrideW-1:0] STRIDE_RST       = 9'd257;

   typedef enum logic [CsrIdxW-1:0] {
      REG_ACTIVE_START = 3'd0,
      REG_ACTIVE_END   = 3'd1,
      REG_VSYNC_START  = 3'd2,
      REG_VSYNC_END    = 3'd3,
      REG_FRAME_FIRST  = 3'd4,
      REG_FRAME_LAST   = 3'd5,
      REG_REPEAT_COUNT = 3'd6,
      REG_LINE_STRIDE  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [LineW-1:0]   active_start;
      logic [LineW-1:0]   active_end;
      logic [LineW-1:0]   vsync_start;
      logic [LineW-1:0]   vsync_end;
      logic [LineW-1:0]   frame_first;
      logic [LineW-1:0]   frame_last;
      logic [RepW-1:0]    repeat_count;
      logic [StrideW-1:0] line_stride;
   } cfg_type;

   typedef struct packed {
      logic [LineW-1:0] scanline;
      logic [SubW-1:0]  sub_line;
      logic [SrcW-1:0]  source_line;
      logic             vblank_flag;
      logic             vsync_out;
   } state_type;

   typedef struct packed {
      logic line_end;
      logic sync_end;
      logic porch_end;
   } event_type;

   typedef struct packed {
      logic               sample_valid;
      logic [LineW-1:0]   sample_index;
      logic               swap_buffers;
      logic               load_source;
      logic [OffsetW-1:0] source_offset;
      logic               start_transfer;
      logic               vsync_level;
      logic               blanking;
      logic               command_valid;
      logic [CmdW-1:0]    command_value;
   } result_type;

endpackage

>>> hw/rtl/vss_line_step.sv
// vss_line_step: next-state and result logic for one transaction of event flags.
// Purely combinational; depends on vss_pkg.

module vss_line_step (
   input  vss_pkg::cfg_type    cfg,
   input  vss_pkg::state_type  cur,
   input  vss_pkg::event_type  ev,
   output vss_pkg::state_type  nxt,
   output vss_pkg::result_type res
);

   logic [vss_pkg::RepW-1:0]    rep;
   logic [vss_pkg::RepW-1:0]    sub_inc;
   logic [vss_pkg::LineW:0]     line_inc;
   logic                        in_active;
   logic [vss_pkg::OffsetW-1:0] offset;

   // 8 x 9 bit product, fits the 17 bit offset exactly
   assign offset = vss_pkg::OffsetW'(cur.source_line) * vss_pkg::OffsetW'(cfg.line_stride);

   always_comb begin
      // clamp repeat count into 1..8
      rep = cfg.repeat_count;
      if (cfg.repeat_count < vss_pkg::REPEAT_MIN) begin
         rep = vss_pkg::REPEAT_MIN;
      end else if (cfg.repeat_count > vss_pkg::REPEAT_MAX) begin
         rep = vss_pkg::REPEAT_MAX;
      end

      in_active = (cur.scanline >= cfg.active_start) && (cur.scanline < cfg.active_end);
      sub_inc   = {1'b0, cur.sub_line} + vss_pkg::RepW'(1);
      line_inc  = {1'b0, cur.scanline} + (vss_pkg::LineW + 1)'(1);

      nxt = cur;
      res = '0;

      if (ev.line_end) begin
         res.sample_valid = 1'b1;
         res.sample_index = cur.scanline;
         res.swap_buffers = (cur.scanline == '0);
         if (in_active) begin
            nxt.vblank_flag = 1'b0;
            if (cur.sub_line == '0) begin
               res.load_source   = 1'b1;
               res.source_offset = offset;
            end
            if (sub_inc >= rep) begin
               nxt.sub_line = '0;
               if (cur.source_line < vss_pkg::SRC_LINE_MAX) begin
                  nxt.source_line = cur.source_line + vss_pkg::SrcW'(1);
               end
            end else begin
               nxt.sub_line = sub_inc[vss_pkg::SubW-1:0];
            end
         end else if (cur.scanline == cfg.active_end) begin
            nxt.vblank_flag   = 1'b1;
            res.command_valid = 1'b1;
            res.command_value = vss_pkg::FRAME_END_CMD;
            nxt.sub_line      = '0;
            nxt.source_line   = '0;
         end else if (cur.scanline == cfg.vsync_start) begin
            nxt.vsync_out = 1'b0;
         end else if (cur.scanline == cfg.vsync_end) begin
            nxt.vsync_out = 1'b1;
         end
         // wrap; a carry out of 10 bits is also past frame_last
         if (line_inc > {1'b0, cfg.frame_last}) begin
            nxt.scanline = cfg.frame_first;
         end else begin
            nxt.scanline = line_inc[vss_pkg::LineW-1:0];
         end
      end else if (ev.sync_end) begin
         if (in_active && (cur.sub_line == vss_pkg::SubW'(1))) begin
            res.command_valid = 1'b1;
            res.command_value = cur.source_line;
         end
      end

      // back porch sees the updated line and sub-line
      if (ev.porch_end && (nxt.scanline >= cfg.active_start) &&
          (nxt.scanline <= cfg.active_end) && (nxt.sub_line == '0)) begin
         res.start_transfer = 1'b1;
      end

      res.vsync_level = nxt.vsync_out;
      res.blanking    = nxt.vblank_flag;
   end

endmodule

>>> hw/rtl/vga_scanline_sequencer.sv
// vga_scanline_sequencer: vertical timing sequencer for a line-repeating VGA output.
// Depends on vss_pkg and vss_line_step.
//
//  channel | ports | carries                                  | handshake
//  --------+-------+------------------------------------------+----------------------
//  events  | req_  | line_end, sync_end, porch_end flags      | req_valid / req_stall
//  result  | rsp_  | sample, swap, DMA offset/pulses, command | rsp_valid / rsp_stall
//  config  | csr_  | index 0..7, 10 bit data                  | csr_write, no wait
//
// One transaction per cycle sustained while rsp_stall is low; after acceptance a
// transaction passes the event register, then the step logic (one 8x9 multiply for
// the DMA offset) into the result register, where rsp_valid rises. The counter state
// updates when a transaction moves into the result register. Reset is synchronous
// and restores the default timing registers and the counters (vsync high). A stalled
// result holds the event register; req_stall rises only when both registers are full.

module vga_scanline_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   // event transactions
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_line_end,
   input  logic                          req_sync_end,
   input  logic                          req_porch_end,
   // result transactions
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_sample_valid,
   output logic [vss_pkg::LineW-1:0]     rsp_sample_index,
   output logic                          rsp_swap_buffers,
   output logic                          rsp_load_source,
   output logic [vss_pkg::OffsetW-1:0]   rsp_source_offset,
   output logic                          rsp_start_transfer,
   output logic                          rsp_vsync_level,
   output logic                          rsp_blanking,
   output logic                          rsp_command_valid,
   output logic [vss_pkg::CmdW-1:0]      rsp_command_value,
   // configuration writes
   input  logic                          csr_write,
   input  logic [vss_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [vss_pkg::LineW-1:0]     csr_data
);

   vss_pkg::cfg_type    cfg_ff,   cfg_in;
   vss_pkg::state_type  state_ff, state_in;
   vss_pkg::event_type  ev_ff,    ev_in;
   vss_pkg::result_type rsp_ff,   rsp_in;
   logic                ev_valid_ff,  ev_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   vss_pkg::state_type  step_state;
   vss_pkg::result_type step_res;

   logic req_take;   // event transaction accepted
   logic advance;    // result register can load this cycle
   logic step_go;    // event register moves into the result register

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step_go   = ev_valid_ff && advance;
   assign req_stall = ev_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   vss_line_step u_step (
      .cfg (cfg_ff),
      .cur (state_ff),
      .ev  (ev_ff),
      .nxt (step_state),
      .res (step_res)
   );

   // configuration register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (vss_pkg::csr_index_type'(csr_index))
            vss_pkg::REG_ACTIVE_START: cfg_in.active_start = csr_data;
            vss_pkg::REG_ACTIVE_END:   cfg_in.active_end   = csr_data;
            vss_pkg::REG_VSYNC_START:  cfg_in.vsync_start  = csr_data;
            vss_pkg::REG_VSYNC_END:    cfg_in.vsync_end    = csr_data;
            vss_pkg::REG_FRAME_FIRST:  cfg_in.frame_first  = csr_data;
            vss_pkg::REG_FRAME_LAST:   cfg_in.frame_last   = csr_data;
            vss_pkg::REG_REPEAT_COUNT: cfg_in.repeat_count = csr_data[vss_pkg::RepW-1:0];
            vss_pkg::REG_LINE_STRIDE:  cfg_in.line_stride  = csr_data[vss_pkg::StrideW-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // pipeline next values
   always_comb begin
      ev_valid_in  = req_take || (ev_valid_ff && !advance);
      ev_in        = req_take ? vss_pkg::event_type'{line_end: req_line_end,
                                                     sync_end: req_sync_end,
                                                     porch_end: req_porch_end} : ev_ff;
      state_in     = step_go ? step_state : state_ff;
      rsp_in       = step_go ? step_res : rsp_ff;
      rsp_valid_in = step_go || (rsp_valid_ff && rsp_stall);
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_start <= vss_pkg::ACTIVE_START_RST;
         cfg_ff.active_end   <= vss_pkg::ACTIVE_END_RST;
         cfg_ff.vsync_start  <= vss_pkg::VSYNC_START_RST;
         cfg_ff.vsync_end    <= vss_pkg::VSYNC_END_RST;
         cfg_ff.frame_first  <= vss_pkg::FRAME_FIRST_RST;
         cfg_ff.frame_last   <= vss_pkg::FRAME_LAST_RST;
         cfg_ff.repeat_count <= vss_pkg::REPEAT_RST;
         cfg_ff.line_stride  <= vss_pkg::STRIDE_RST;
         state_ff.scanline    <= '0;
         state_ff.sub_line    <= '0;
         state_ff.source_line <= '0;
         state_ff.vblank_flag <= 1'b0;
         state_ff.vsync_out   <= 1'b1;   // sync inactive
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      ev_ff  <= ev_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_valid   = rsp_ff.sample_valid;
   assign rsp_sample_index   = rsp_ff.sample_index;
   assign rsp_swap_buffers   = rsp_ff.swap_buffers;
   assign rsp_load_source    = rsp_ff.load_source;
   assign rsp_source_offset  = rsp_ff.source_offset;
   assign rsp_start_transfer = rsp_ff.start_transfer;
   assign rsp_vsync_level    = rsp_ff.vsync_level;
   assign rsp_blanking       = rsp_ff.blanking;
   assign rsp_command_valid  = rsp_ff.command_valid;
   assign rsp_command_value  = rsp_ff.command_value;

   // ---- assertions ----

   // reset brings back the idle frame position with vsync released
   a_reset_state: assert property (@(posedge clock)
      reset |=> (state_ff.scanline == '0) && state_ff.vsync_out && !rsp_valid_ff)
      else $error("counter state not cleared by reset");

   // scanline only moves on a line-end transaction
   a_line_hold: assert property (@(posedge clock) disable iff (reset)
      step_go && !ev_ff.line_end |=> $stable(state_ff.scanline))
      else $error("scanline changed without a line-end event");

   // swap pulse only with a sample at line zero
   a_swap_line0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.swap_buffers |->
         rsp_ff.sample_valid && (rsp_ff.sample_index == '0))
      else $error("buffer swap outside scanline zero");

   // DMA load only on a line end, offset zero otherwise
   a_load_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.load_source || (rsp_ff.source_offset != '0)) |->
         rsp_ff.sample_valid && (rsp_ff.load_source || (rsp_ff.source_offset == '0)))
      else $error("DMA offset without a load on a line end");

endmodule

>>> sim/vss_result_checker.sv
// vss_result_checker: predicts the result of every event transaction of the scanline
// sequencer and compares it with what comes out. Depends on vss_pkg only.

module vss_result_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_line_end,
   input  logic                        req_sync_end,
   input  logic                        req_porch_end,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        rsp_sample_valid,
   input  logic [vss_pkg::LineW-1:0]   rsp_sample_index,
   input  logic                        rsp_swap_buffers,
   input  logic                        rsp_load_source,
   input  logic [vss_pkg::OffsetW-1:0] rsp_source_offset,
   input  logic                        rsp_start_transfer,
   input  logic                        rsp_vsync_level,
   input  logic                        rsp_blanking,
   input  logic                        rsp_command_valid,
   input  logic [vss_pkg::CmdW-1:0]    rsp_command_value,
   input  logic                        csr_write,
   input  logic [vss_pkg::CsrIdxW-1:0] csr_index,
   input  logic [vss_pkg::LineW-1:0]   csr_data,
   output int                          fail_count,
   output int                          due_count
);

   vss_pkg::cfg_type            timing;
   logic [vss_pkg::LineW-1:0]   cur_line;
   logic [vss_pkg::SubW-1:0]    cur_sub;
   logic [vss_pkg::SrcW-1:0]    cur_src;
   logic                        blank_q;
   logic                        vsync_q;
   vss_pkg::result_type         due_results[$];

   initial begin
      fail_count = 0;
      due_count  = 0;
   end

   // one event transaction: line end first, sync end only without a line end,
   // porch end last against the updated line
   function automatic vss_pkg::result_type advance_line(input logic le, input logic se,
                                                        input logic pe);
      vss_pkg::result_type         r;
      logic [vss_pkg::RepW-1:0]    rep;
      logic [vss_pkg::RepW-1:0]    sub_n;
      logic [vss_pkg::LineW:0]     nxt;
      logic [vss_pkg::OffsetW-1:0] src_w;
      logic [vss_pkg::OffsetW-1:0] stride_w;
      logic                        act;
      r   = '0;
      act = (cur_line >= timing.active_start) && (cur_line < timing.active_end);
      if (le) begin
         rep = timing.repeat_count;
         if (rep < vss_pkg::REPEAT_MIN) rep = vss_pkg::REPEAT_MIN;
         if (rep > vss_pkg::REPEAT_MAX) rep = vss_pkg::REPEAT_MAX;
         r.sample_valid = 1'b1;
         r.sample_index = cur_line;
         r.swap_buffers = (cur_line == '0);
         if (act) begin
            blank_q = 1'b0;
            if (cur_sub == '0) begin
               src_w    = vss_pkg::OffsetW'(cur_src);
               stride_w = vss_pkg::OffsetW'(timing.line_stride);
               r.load_source   = 1'b1;
               r.source_offset = src_w * stride_w;
            end
            sub_n = {1'b0, cur_sub} + 1'b1;
            if (sub_n >= rep) begin
               sub_n = '0;
               if (cur_src < vss_pkg::SRC_LINE_MAX) cur_src = cur_src + 1'b1;
            end
            cur_sub = sub_n[vss_pkg::SubW-1:0];
         end else if (cur_line == timing.active_end) begin
            blank_q         = 1'b1;
            r.command_valid = 1'b1;
            r.command_value = vss_pkg::FRAME_END_CMD;
            cur_sub         = '0;
            cur_src         = '0;
         end else if (cur_line == timing.vsync_start) begin
            vsync_q = 1'b0;
         end else if (cur_line == timing.vsync_end) begin
            vsync_q = 1'b1;
         end
         nxt = {1'b0, cur_line} + 1'b1;
         if (nxt > {1'b0, timing.frame_last}) nxt = {1'b0, timing.frame_first};
         cur_line = nxt[vss_pkg::LineW-1:0];
      end else if (se) begin
         if (act && cur_sub == vss_pkg::SubW'(1)) begin
            r.command_valid = 1'b1;
            r.command_value = cur_src;
         end
      end
      if (pe && cur_line >= timing.active_start && cur_line <= timing.active_end &&
          cur_sub == '0)
         r.start_transfer = 1'b1;
      r.vsync_level = vsync_q;
      r.blanking    = blank_q;
      return r;
   endfunction

   function automatic string show(input vss_pkg::result_type r);
      return $sformatf({"sv=%0d idx=%0d swap=%0d ld=%0d off=%0d st=%0d",
                        " vs=%0d bl=%0d cv=%0d cmd=%0d"},
                       r.sample_valid, r.sample_index, r.swap_buffers, r.load_source,
                       r.source_offset, r.start_transfer, r.vsync_level, r.blanking,
                       r.command_valid, r.command_value);
   endfunction

   always @(posedge clock) begin : watch
      vss_pkg::result_type got;
      vss_pkg::result_type want;
      if (reset) begin
         timing   = '{vss_pkg::ACTIVE_START_RST, vss_pkg::ACTIVE_END_RST,
                      vss_pkg::VSYNC_START_RST, vss_pkg::VSYNC_END_RST,
                      vss_pkg::FRAME_FIRST_RST, vss_pkg::FRAME_LAST_RST,
                      vss_pkg::REPEAT_RST, vss_pkg::STRIDE_RST};
         cur_line = '0;
         cur_sub  = '0;
         cur_src  = '0;
         blank_q  = 1'b0;
         vsync_q  = 1'b1;
         due_results.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               vss_pkg::REG_ACTIVE_START: timing.active_start = csr_data;
               vss_pkg::REG_ACTIVE_END:   timing.active_end   = csr_data;
               vss_pkg::REG_VSYNC_START:  timing.vsync_start  = csr_data;
               vss_pkg::REG_VSYNC_END:    timing.vsync_end    = csr_data;
               vss_pkg::REG_FRAME_FIRST:  timing.frame_first  = csr_data;
               vss_pkg::REG_FRAME_LAST:   timing.frame_last   = csr_data;
               vss_pkg::REG_REPEAT_COUNT:
                  timing.repeat_count = csr_data[vss_pkg::RepW-1:0];
               vss_pkg::REG_LINE_STRIDE:
                  timing.line_stride  = csr_data[vss_pkg::StrideW-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_sample_valid, rsp_sample_index, rsp_swap_buffers, rsp_load_source,
                   rsp_source_offset, rsp_start_transfer, rsp_vsync_level, rsp_blanking,
                   rsp_command_valid, rsp_command_value};
            if (due_results.size() == 0) begin
               if (fail_count < 10)
                  $display("checker: result with nothing due: %s", show(got));
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("checker: mismatch at %0t", $realtime);
                     $display("   expected %s", show(want));
                     $display("   actual   %s", show(got));
                  end
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            due_results.push_back(advance_line(req_line_end, req_sync_end, req_porch_end));
      end
      due_count = due_results.size();
   end

endmodule

>>> sim/testbench.sv
// testbench: top of the scanline sequencer test; drives event transactions, timing
// registers and result back-pressure. Depends on vss_pkg, vss_result_checker and
// vga_scanline_sequencer.

module testbench;

   // cycles with no transaction at all before the run is declared hung
   localparam int QuietLimit = 1000;
   // long receiver hold-off, fills the two-deep pipe and stalls the input
   localparam int HoldCycles = 60;

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_stall;
   logic                          req_line_end  = 1'b0;
   logic                          req_sync_end  = 1'b0;
   logic                          req_porch_end = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall     = 1'b0;
   logic                          rsp_sample_valid;
   logic [vss_pkg::LineW-1:0]     rsp_sample_index;
   logic                          rsp_swap_buffers;
   logic                          rsp_load_source;
   logic [vss_pkg::OffsetW-1:0]   rsp_source_offset;
   logic                          rsp_start_transfer;
   logic                          rsp_vsync_level;
   logic                          rsp_blanking;
   logic                          rsp_command_valid;
   logic [vss_pkg::CmdW-1:0]      rsp_command_value;
   logic                          csr_write     = 1'b0;
   logic [vss_pkg::CsrIdxW-1:0]   csr_index     = vss_pkg::REG_ACTIVE_START;
   logic [vss_pkg::LineW-1:0]     csr_data      = '0;

   int fail_count;
   int due_count;

   // stimulus controls: calm turns off all idling, each hold_req step asks for
   // one long stall
   bit calm     = 1'b0;
   int hold_req = 0;
   int sent     = 0;
   int setups   = 0;
   int quiet    = 0;

   vga_scanline_sequencer u_dut (.*);

   vss_result_checker u_check (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog: counts cycles in which nothing is accepted and nothing is written
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QuietLimit) begin
            $display("testbench: no transaction for %0d cycles", QuietLimit);
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, open stretches, and one long hold-off on request.
   // Each pass makes one assignment and then waits on the clock before the next pass.
   initial begin : receiver
      int holds_done;
      holds_done = 0;
      forever begin
         if (hold_req > holds_done) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            holds_done++;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // one event transaction; valid stays high into the next one unless a gap is taken.
   // Stall is read right after the edge, so it is the value the edge saw.
   task automatic send_event(input logic le, input logic se, input logic pe);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_line_end  <= le;
      req_sync_end  <= se;
      req_porch_end <= pe;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   // sender pause: stop offering and wait, between edges, until no result is due
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (due_count != 0);
      @(posedge clock);
   endtask

   task automatic write_reg(input vss_pkg::csr_index_type idx,
                            input logic [vss_pkg::LineW-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
   endtask

   // registers change only with the block idle
   task automatic program_timing(input logic [vss_pkg::LineW-1:0] as,
                                 input logic [vss_pkg::LineW-1:0] ae,
                                 input logic [vss_pkg::LineW-1:0] vs,
                                 input logic [vss_pkg::LineW-1:0] ve,
                                 input logic [vss_pkg::LineW-1:0] ff,
                                 input logic [vss_pkg::LineW-1:0] fl,
                                 input logic [vss_pkg::LineW-1:0] rc,
                                 input logic [vss_pkg::LineW-1:0] ls);
      drain();
      write_reg(vss_pkg::REG_ACTIVE_START, as);
      write_reg(vss_pkg::REG_ACTIVE_END,   ae);
      write_reg(vss_pkg::REG_VSYNC_START,  vs);
      write_reg(vss_pkg::REG_VSYNC_END,    ve);
      write_reg(vss_pkg::REG_FRAME_FIRST,  ff);
      write_reg(vss_pkg::REG_FRAME_LAST,   fl);
      write_reg(vss_pkg::REG_REPEAT_COUNT, rc);
      write_reg(vss_pkg::REG_LINE_STRIDE,  ls);
      csr_write <= 1'b0;
      setups++;
   endtask

   // small frames so that a few hundred transactions sweep many frames; the
   // narrow range makes register coincidences common. Full 10-bit data on
   // repeat count and stride exercises the ignored upper bits and the clamps.
   task automatic random_timing();
      logic [vss_pkg::LineW-1:0] fl;
      logic [vss_pkg::LineW-1:0] as;
      logic [vss_pkg::LineW-1:0] ae;
      fl = vss_pkg::LineW'($urandom_range(4, 40));
      as = vss_pkg::LineW'($urandom_range(0, fl));
      ae = vss_pkg::LineW'($urandom_range(as, fl + 2));
      program_timing(as, ae, vss_pkg::LineW'($urandom_range(0, fl + 2)),
                     vss_pkg::LineW'($urandom_range(0, fl + 2)),
                     vss_pkg::LineW'($urandom_range(0, 3)), fl,
                     vss_pkg::LineW'($urandom_range(0, 1023)),
                     vss_pkg::LineW'($urandom_range(0, 1023)));
   endtask

   // line ends with random sync and porch flags riding along
   task automatic run_lines(input int n);
      repeat (n) send_event(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // mostly well-formed video lines (line end, sync end, porch end in turn),
   // the rest arbitrary event combinations
   task automatic run_mixed(input int n);
      int done_n;
      done_n = 0;
      while (done_n < n) begin
         if ($urandom_range(0, 3) != 0) begin
            send_event(1'b1, 1'b0, 1'($urandom_range(0, 7) == 0));
            send_event(1'b0, 1'b1, 1'($urandom_range(0, 3) == 0));
            send_event(1'b0, 1'b0, 1'b1);
            done_n += 3;
         end else begin
            send_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
            done_n++;
         end
      end
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset timing: every flag combination, the first line end at scanline 0
      for (int i = 0; i < 8; i++)
         send_event(1'(i >> 2), 1'(i >> 1), 1'(i));

      // tiny frame: vsync low and high, wrap, active lines with load, sync
      // command on the second repeat, frame end command and porch starts
      program_timing(10'd1, 10'd3, 10'd4, 10'd5, 10'd0, 10'd6, 10'd2, 10'd511);
      repeat (7) begin
         send_event(1'b1, 1'b0, 1'b1);
         send_event(1'b0, 1'b1, 1'b1);
      end

      // first above last: the wrap sticks at frame_first; then a wrap past 1023
      program_timing(10'd2, 10'd3, 10'd1021, 10'd1022, 10'd1020, 10'd5, 10'd1, 10'd3);
      run_lines(4);
      program_timing(10'd2, 10'd3, 10'd1021, 10'd1022, 10'd1020, 10'd1023, 10'd1, 10'd3);
      run_lines(6);

      // one long active region with repeat count zero: source line saturates.
      // The receiver holds off for a long stretch while events keep coming.
      program_timing(10'd0, 10'd1000, 10'd1010, 10'd1011, 10'd0, 10'd1023, 10'd0, 10'd511);
      hold_req++;
      run_lines(300);

      for (int k = 0; k < 8; k++) begin
         random_timing();
         if (k == 2) hold_req++;
         run_mixed(140);
      end

      // register extremes
      program_timing('0, '0, '0, '0, '0, '0, '0, '0);
      run_mixed(40);
      program_timing('1, '1, '1, '1, '1, '1, '1, '1);
      run_mixed(40);

      // closing part without any idling on either side
      calm = 1'b1;
      random_timing();
      run_mixed(100);

      drain();
      repeat (8) @(posedge clock);
      @(negedge clock);
      $display("summary: %0d event transactions over %0d register setups,", sent, setups);
      $display("summary: incl. wrap past 1023, source line saturation and long back-pressure");
      if (fail_count == 0 && due_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/vss_pkg.sv
hw/rtl/vss_line_step.sv
hw/rtl/vga_scanline_sequencer.sv
sim/vss_result_checker.sv
sim/testbench.sv
